// File: sv/key_debounce_short_long_repeat_assert.svh
// Assertion helpers shared by the key debounce modules.
`ifndef KEY_DEBOUNCE_SHORT_LONG_REPEAT_ASSERT_SVH
`define KEY_DEBOUNCE_SHORT_LONG_REPEAT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KDSLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KDSLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/kdslr_pkg.sv
package kdslr_pkg;

    localparam int NUM_KEYS    = 2;
    localparam int PIN_WIDTH   = 2;
    localparam int EVENT_WIDTH = 2;
    localparam int DATA_WIDTH  = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] HOLD_LIMIT_MS = 16'd60000;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_SAMPLES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP_MS     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL  = 4'd3;

    localparam logic [3:0]  RST_DEBOUNCE_SAMPLES = 4'd2;
    localparam logic [7:0]  RST_TICK_STEP_MS     = 8'd10;
    localparam logic [15:0] RST_LONG_PRESS_MS    = 16'd600;
    localparam logic [15:0] RST_REPEAT_INTERVAL  = 16'd100;

    typedef struct packed {
        logic [3:0]  debounce_samples;
        logic [7:0]  tick_step_ms;
        logic [15:0] long_press_ms;
        logic [15:0] repeat_interval_ms;
    } cfg_t;

endpackage

// File: sv/kdslr_key.sv
module kdslr_key
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             pressed,
    input  kdslr_pkg::cfg_t  cfg,
    output logic             fire
);
    import kdslr_pkg::*;

    logic        last_reg;
    logic        last_next;
    logic [3:0]  agree_reg;
    logic [3:0]  agree_next;
    logic        stable_reg;
    logic        stable_next;
    logic [15:0] hold_reg;
    logic [15:0] hold_next;
    logic [15:0] repeat_reg;
    logic [15:0] repeat_next;
    logic [15:0] hold_mid;
    logic [15:0] repeat_mid;
    logic [15:0] repeat_sum;
    logic        short_fire;
    logic        long_fire;

    always_comb
    begin
        last_next   = last_reg;
        agree_next  = agree_reg;
        stable_next = stable_reg;
        hold_mid    = hold_reg;
        repeat_mid  = repeat_reg;
        short_fire  = 1'b0;

        // debounce
        if (pressed != last_reg)
        begin
            last_next  = pressed;
            agree_next = 4'd0;
        end
        else if (agree_reg < cfg.debounce_samples)
        begin
            agree_next = agree_reg + 4'd1;
            if ((agree_next == cfg.debounce_samples) && (pressed != stable_reg))
            begin
                stable_next = pressed;
                if (pressed)
                begin
                    hold_mid   = 16'd0;
                    repeat_mid = 16'd0;
                end
                else
                begin
                    short_fire = (hold_reg != 16'd0) && (hold_reg < cfg.long_press_ms);
                    hold_mid   = 16'd0;
                end
            end
        end

        // hold timer and auto-repeat
        hold_next   = hold_mid;
        repeat_next = repeat_mid;
        repeat_sum  = repeat_mid + {8'd0, cfg.tick_step_ms};
        long_fire   = 1'b0;
        if (stable_next)
        begin
            if (hold_mid < HOLD_LIMIT_MS)
            begin
                hold_next = hold_mid + {8'd0, cfg.tick_step_ms};
            end
            if (hold_next == cfg.long_press_ms)
            begin
                repeat_next = 16'd0;
                long_fire   = 1'b1;
            end
            else if (hold_next > cfg.long_press_ms)
            begin
                if (repeat_sum >= cfg.repeat_interval_ms)
                begin
                    repeat_next = 16'd0;
                    long_fire   = 1'b1;
                end
                else
                begin
                    repeat_next = repeat_sum;
                end
            end
        end
    end

    assign fire = short_fire | long_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= 1'b0;
            agree_reg  <= 4'd0;
            stable_reg <= 1'b0;
            hold_reg   <= 16'd0;
            repeat_reg <= 16'd0;
        end
        else if (en)
        begin
            last_reg   <= last_next;
            agree_reg  <= agree_next;
            stable_reg <= stable_next;
            hold_reg   <= hold_next;
            repeat_reg <= repeat_next;
        end
    end

`include "key_debounce_short_long_repeat_assert.svh"

    `KDSLR_ASSERT_NOW(a_hold_bounded, 1'b1, hold_reg <= (HOLD_LIMIT_MS + 16'd255),
        "hold timer beyond saturation range")
    `KDSLR_ASSERT_NOW(a_flip_on_agree, en && (stable_next != stable_reg),
        (agree_next == cfg.debounce_samples) && (pressed == last_reg),
        "stable state flipped without full agreement")
    `KDSLR_ASSERT_NOW(a_short_only_early, en && short_fire,
        !stable_next && (hold_reg < cfg.long_press_ms) && !long_fire,
        "short press fired outside an early release")

endmodule

// File: sv/key_debounce_short_long_repeat.sv
// Key debounce with short press, long press and auto-repeat. Each s_ transaction
// is one scan tick carrying the active-low pin levels of the keys; each tick
// yields exactly one m_ transaction whose key_event is 0 (nothing fired) or
// k (key k-1 fired, lowest index wins). A key fires once on a release before
// long_press_ms, once when its hold time equals long_press_ms, and then every
// repeat_interval_ms. One tick is taken per clock cycle while the output is not
// stalled; each tick passes through an input register and a result register,
// with the per-key state updated as it moves between them. A stalled m_tready
// backs up through the result register, then the input register, before
// s_tready drops. The user must write registers through cfg_we/cfg_index/cfg_data
// only while no tick is in flight; the block itself does not enforce it.
module key_debounce_short_long_repeat
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kdslr_pkg::DATA_WIDTH-1:0]    s_tdata,   // [1:0] pin_levels
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kdslr_pkg::DATA_WIDTH-1:0]    m_tdata,   // [1:0] key_event
    input  logic                                cfg_we,
    input  logic [kdslr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kdslr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kdslr_pkg::*;

    cfg_t                   cfg_reg;
    logic                   in_valid_reg;
    logic [PIN_WIDTH-1:0]   pins_reg;
    logic                   out_valid_reg;
    logic [EVENT_WIDTH-1:0] event_reg;
    logic [EVENT_WIDTH-1:0] event_next;
    logic                   out_free;
    logic                   advance;
    logic [NUM_KEYS-1:0]    key_pressed;
    logic [NUM_KEYS-1:0]    key_fire;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_samples   <= RST_DEBOUNCE_SAMPLES;
            cfg_reg.tick_step_ms       <= RST_TICK_STEP_MS;
            cfg_reg.long_press_ms      <= RST_LONG_PRESS_MS;
            cfg_reg.repeat_interval_ms <= RST_REPEAT_INTERVAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_SAMPLES: cfg_reg.debounce_samples   <= cfg_data[3:0];
                REG_TICK_STEP_MS:     cfg_reg.tick_step_ms       <= cfg_data[7:0];
                REG_LONG_PRESS_MS:    cfg_reg.long_press_ms      <= cfg_data;
                REG_REPEAT_INTERVAL:  cfg_reg.repeat_interval_ms <= cfg_data;
                default:              ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pins_reg <= s_tdata[PIN_WIDTH-1:0];
        end
    end

    // keys past the pin field read as released
    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++)
        begin : g_key
            if (k < PIN_WIDTH)
            begin : g_pin
                assign key_pressed[k] = !pins_reg[k];
            end
            else
            begin : g_none
                assign key_pressed[k] = 1'b0;
            end

            kdslr_key u_key
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (advance),
                .pressed (key_pressed[k]),
                .cfg     (cfg_reg),
                .fire    (key_fire[k])
            );
        end
    endgenerate

    always_comb
    begin
        event_next = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (key_fire[i])
            begin
                event_next = EVENT_WIDTH'(i + 1);
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg <= event_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DATA_WIDTH - EVENT_WIDTH){1'b0}}, event_reg};

`include "key_debounce_short_long_repeat_assert.svh"

    `KDSLR_ASSERT_NEXT(a_advance_shows, advance, m_tvalid,
        "processed tick did not reach the result register")
    `KDSLR_ASSERT_NOW(a_stall_cause, !s_tready, in_valid_reg && m_tvalid && !m_tready,
        "input stalled without a full pipeline")
    `KDSLR_ASSERT_NOW(a_event_range, m_tvalid, 32'(event_reg) <= NUM_KEYS,
        "event names a key that does not exist")

endmodule

// File: test/tb_top.sv
module tb_top;

    import kdslr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd11;

    localparam logic [EVENT_WIDTH-1:0] EV_NONE = 2'd0;

    localparam logic [PIN_WIDTH-1:0] PINS_NONE = 2'b11;
    localparam logic [PIN_WIDTH-1:0] PINS_KEY0 = 2'b10;
    localparam logic [PIN_WIDTH-1:0] PINS_KEY1 = 2'b01;
    localparam logic [PIN_WIDTH-1:0] PINS_BOTH = 2'b00;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_TICKS    = 1400;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [DATA_WIDTH-1:0]    s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [DATA_WIDTH-1:0]    m_tdata;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    // key state mirror
    cfg_t        key_cfg;
    logic        raw_pressed [NUM_KEYS];
    logic [3:0]  agree_cnt   [NUM_KEYS];
    logic        key_down    [NUM_KEYS];
    logic [15:0] held_ms     [NUM_KEYS];
    logic [15:0] repeat_ms   [NUM_KEYS];

    logic [EVENT_WIDTH-1:0] key_event_q [$];

    int errors;
    int ticks_sent;
    int idle_cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_len;

    key_debounce_short_long_repeat DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [1:0] pin_levels
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [1:0] key_event
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [EVENT_WIDTH-1:0] predict_key_event(logic [PIN_WIDTH-1:0] pins);
        logic [EVENT_WIDTH-1:0] ev;
        logic                   pressed;
        ev = EV_NONE;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            pressed = (k < PIN_WIDTH) ? !pins[k] : 1'b0;
            if (pressed != raw_pressed[k])
            begin
                raw_pressed[k] = pressed;
                agree_cnt[k] = 4'd0;
            end
            else if (agree_cnt[k] < key_cfg.debounce_samples)
            begin
                agree_cnt[k] = agree_cnt[k] + 4'd1;
                if (agree_cnt[k] == key_cfg.debounce_samples && pressed != key_down[k])
                begin
                    key_down[k] = pressed;
                    if (pressed)
                    begin
                        held_ms[k] = 16'd0;
                        repeat_ms[k] = 16'd0;
                    end
                    else
                    begin
                        // short press fires on release only
                        if (held_ms[k] > 16'd0 && held_ms[k] < key_cfg.long_press_ms
                            && ev == EV_NONE)
                            ev = 2'(k + 1);
                        held_ms[k] = 16'd0;
                    end
                end
            end
            if (key_down[k])
            begin
                if (held_ms[k] < HOLD_LIMIT_MS)
                    held_ms[k] = held_ms[k] + 16'(key_cfg.tick_step_ms);
                if (held_ms[k] == key_cfg.long_press_ms)
                begin
                    repeat_ms[k] = 16'd0;
                    if (ev == EV_NONE)
                        ev = 2'(k + 1);
                end
                else if (held_ms[k] > key_cfg.long_press_ms)
                begin
                    repeat_ms[k] = repeat_ms[k] + 16'(key_cfg.tick_step_ms);
                    if (repeat_ms[k] >= key_cfg.repeat_interval_ms)
                    begin
                        repeat_ms[k] = 16'd0;
                        if (ev == EV_NONE)
                            ev = 2'(k + 1);
                    end
                end
            end
        end
        return ev;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                key_event_q.push_back(predict_key_event(s_tdata[PIN_WIDTH-1:0]));
            if (m_tvalid && m_tready)
            begin
                if (key_event_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction, actual key_event %0d",
                             $time, m_tdata[EVENT_WIDTH-1:0]);
                    errors++;
                end
                else
                begin
                    logic [EVENT_WIDTH-1:0] want;
                    want = key_event_q.pop_front();
                    if (m_tdata[EVENT_WIDTH-1:0] !== want)
                    begin
                        $display("%0t: key_event mismatch, expected %0d actual %0d",
                                 $time, want, m_tdata[EVENT_WIDTH-1:0]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // receiver
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_len) @(negedge clk);
                rx_hold_len = 0;
                m_tready <= 1'b1;
            end
            else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_tick(logic [PIN_WIDTH-1:0] pins);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {{(DATA_WIDTH-PIN_WIDTH){1'b0}}, pins};
        do @(posedge clk); while (!s_tready);
        ticks_sent++;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (key_event_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_DEBOUNCE_SAMPLES: key_cfg.debounce_samples = data[3:0];
            REG_TICK_STEP_MS:     key_cfg.tick_step_ms = data[7:0];
            REG_LONG_PRESS_MS:    key_cfg.long_press_ms = data;
            REG_REPEAT_INTERVAL:  key_cfg.repeat_interval_ms = data;
            default: ;
        endcase
    endtask

    // upper bits of the narrow registers carry junk on purpose
    task automatic set_config(logic [3:0] db, logic [7:0] step, logic [15:0] lp,
                              logic [15:0] ri);
        drain_results();
        repeat (4) @(posedge clk);
        write_reg(REG_DEBOUNCE_SAMPLES, {12'($urandom), db});
        write_reg(REG_TICK_STEP_MS, {8'($urandom), step});
        write_reg(REG_LONG_PRESS_MS, lp);
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_REPEAT_INTERVAL, ri);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic press_sequence(int max_press);
        int               kind;
        int               len;
        int               db;
        int               tl;
        int               rt;
        logic [PIN_WIDTH-1:0] held;
        logic [PIN_WIDTH-1:0] pins;
        db = int'(key_cfg.debounce_samples);
        if (key_cfg.tick_step_ms == 8'd0)
        begin
            tl = 4;
            rt = 4;
        end
        else
        begin
            tl = int'(key_cfg.long_press_ms) / int'(key_cfg.tick_step_ms) + 1;
            rt = int'(key_cfg.repeat_interval_ms) / int'(key_cfg.tick_step_ms) + 1;
        end
        if (tl > max_press)
            tl = max_press;
        if (rt > max_press)
            rt = max_press;
        kind = $urandom_range(0, 99);
        held = 2'($urandom_range(0, 2));
        if (kind < 40)
            len = $urandom_range(1, db + tl);
        else if (kind < 85)
            len = db + 1 + tl + $urandom_range(0, 3 * rt);
        else
            len = $urandom_range(1, 12);
        if (len > max_press)
            len = max_press;
        for (int i = 0; i < len; i++)
        begin
            if (kind >= 85)
                pins = 2'($urandom_range(0, 3));
            else if ($urandom_range(0, 99) < 4)
                pins = held ^ (2'b01 << $urandom_range(0, 1));
            else
                pins = held;
            send_tick(pins);
        end
        repeat (db + 1 + $urandom_range(0, 4)) send_tick(PINS_NONE);
    endtask

    task automatic test_short_long_repeat();
        set_config(4'd1, 8'd100, 16'd300, 16'd0);
        tx_idle_pct = 15;
        rx_idle_pct = 15;
        send_tick(PINS_NONE);
        repeat (5) send_tick(PINS_KEY0);
        repeat (3) send_tick(PINS_NONE);
        repeat (2) send_tick(PINS_BOTH);
        repeat (2) send_tick(PINS_NONE);
        repeat (2) send_tick(PINS_KEY1);
        repeat (2) send_tick(PINS_NONE);
    endtask

    task automatic test_zero_debounce();
        set_config(4'd0, 8'd10, 16'd10, 16'd5);
        repeat (3) send_tick(PINS_BOTH);
        send_tick(PINS_NONE);
    endtask

    task automatic test_odd_long_press();
        set_config(4'd1, 8'd100, 16'd250, 16'd150);
        repeat (5) send_tick(PINS_KEY1);
        repeat (2) send_tick(PINS_NONE);
    endtask

    task automatic test_hold_saturation();
        set_config(4'd15, 8'd255, 16'd60000, 16'd255);
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        repeat (258) send_tick(PINS_KEY1);
        repeat (18) send_tick(PINS_NONE);
    endtask

    task automatic test_repeat_wrap();
        set_config(4'd1, 8'd250, 16'd250, 16'd65535);
        repeat (272) send_tick(PINS_KEY0);
        repeat (4) send_tick(PINS_NONE);
    endtask

    task automatic test_output_backpressure();
        set_config(4'd1, 8'd10, 16'd30, 16'd20);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_len = 150;
        repeat (40) send_tick(2'($urandom_range(0, 3)));
    endtask

    task automatic test_random_phases(int until_ticks);
        logic [3:0]  db;
        logic [7:0]  step;
        logic [15:0] lp;
        logic [15:0] ri;
        int          phase_end;
        while (ticks_sent < until_ticks)
        begin
            db = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 4));
            case ($urandom_range(0, 4))
                0:       step = 8'd1;
                1:       step = 8'd255;
                2:       step = 8'($urandom_range(0, 255));
                default: step = 8'($urandom_range(1, 60));
            endcase
            case ($urandom_range(0, 5))
                0:       lp = 16'($urandom_range(1, 12 * step + 1));
                1:       lp = ($urandom_range(0, 1) != 0) ? 16'd1 : 16'($urandom_range(0, 65535));
                default: lp = 16'(step * $urandom_range(1, 10));
            endcase
            case ($urandom_range(0, 3))
                0:       ri = 16'($urandom_range(0, 1000));
                1:       ri = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom_range(0, 65535));
                default: ri = 16'(step * $urandom_range(0, 5));
            endcase
            set_config(db, step, lp, ri);
            tx_idle_pct = 15 * $urandom_range(0, 2);
            rx_idle_pct = 15 * $urandom_range(0, 2);
            phase_end = ticks_sent + $urandom_range(60, 120);
            while (ticks_sent < phase_end)
                press_sequence(40);
        end
    endtask

    task automatic test_quiet_tail(int until_ticks);
        set_config(RST_DEBOUNCE_SAMPLES, RST_TICK_STEP_MS, RST_LONG_PRESS_MS,
                   RST_REPEAT_INTERVAL);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (ticks_sent < until_ticks)
            press_sequence(80);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        ticks_sent = 0;
        idle_cycles = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_len = 0;
        key_cfg.debounce_samples = RST_DEBOUNCE_SAMPLES;
        key_cfg.tick_step_ms = RST_TICK_STEP_MS;
        key_cfg.long_press_ms = RST_LONG_PRESS_MS;
        key_cfg.repeat_interval_ms = RST_REPEAT_INTERVAL;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            raw_pressed[k] = 1'b0;
            agree_cnt[k] = 4'd0;
            key_down[k] = 1'b0;
            held_ms[k] = 16'd0;
            repeat_ms[k] = 16'd0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_short_long_repeat();
        test_zero_debounce();
        test_odd_long_press();
        test_hold_saturation();
        test_repeat_wrap();
        test_output_backpressure();
        test_random_phases(TOTAL_TICKS - 150);
        test_quiet_tail(TOTAL_TICKS);

        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0 && key_event_q.size() == 0)
            $display("status: pass");
        else
        begin
            if (key_event_q.size() != 0)
                $display("%0t: %0d results never arrived", $time, key_event_q.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
